[rtl/voxel_height_neighbor_difference_assert.svh]
`ifndef VOXEL_HEIGHT_NEIGHBOR_DIFFERENCE_ASSERT_SVH
`define VOXEL_HEIGHT_NEIGHBOR_DIFFERENCE_ASSERT_SVH

// same-cycle implication, clocked on aclk, off during reset
`define VHND_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VHND_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/vhnd_pkg.sv]
package vhnd_pkg;

    localparam int BITS_W      = 64;
    localparam int COL_CFG_W   = 11;
    localparam int ROW_CFG_W   = 13;
    localparam int DEPTH_CFG_W = 7;
    localparam int ROW_W       = 12;
    localparam int DIFF_W      = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int COUNT_W     = 4;

    localparam int ROWS_MAX    = 4096;
    localparam int DIFF_MAX    = 32767;
    localparam int DIFF_MIN_MAG = 32768;

    localparam logic [COL_CFG_W-1:0]   COLUMNS_RESET = 11'd1024;
    localparam logic [ROW_CFG_W-1:0]   ROWS_RESET    = 13'd1024;
    localparam logic [DEPTH_CFG_W-1:0] DEPTH_RESET   = 7'd64;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH   = 2'd2;

endpackage

[rtl/vhnd_ram.sv]
module vhnd_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first on a same-address collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/vhnd_height.sv]
module vhnd_height #(
    parameter int MAX_DEPTH = 64,
    parameter int HEIGHT_W  = $clog2(MAX_DEPTH + 1)
) (
    input  logic [vhnd_pkg::BITS_W-1:0]      column_bits,
    input  logic [vhnd_pkg::DEPTH_CFG_W-1:0] depth,
    output logic [HEIGHT_W-1:0]              height
);

    import vhnd_pkg::*;

    localparam logic [DEPTH_CFG_W-1:0] DEPTH_LIMIT = DEPTH_CFG_W'(MAX_DEPTH);

    logic [DEPTH_CFG_W-1:0] depth_eff;

    assign depth_eff = (depth > DEPTH_LIMIT) ? DEPTH_LIMIT : depth;

    // highest occupied voxel below the depth limit
    always_comb begin
        height = '0;
        for (int z = 0; z < MAX_DEPTH; z++) begin
            if (column_bits[z] && (DEPTH_CFG_W'(z) < depth_eff)) begin
                height = HEIGHT_W'(z + 1);
            end
        end
    end

endmodule

[rtl/voxel_height_neighbor_difference.sv]
// Path: stage 1, stage 2, stage 3, output register. Throughput: one word per
// cycle unless m_ready stalls the output; the line store is read on accept and
// written back when stage 1 fires, forwarding back-to-back hits on one entry.
// Reset: positions, 3x3 window, pipeline valids and configuration registers
// go to defaults; the line store is not cleared and needs no clearing pass.
`include "voxel_height_neighbor_difference_assert.svh"

module voxel_height_neighbor_difference #(
    parameter int MAX_COLUMNS   = 1024,
    parameter int MAX_DEPTH     = 64,
    parameter int FRACTION_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vhnd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [vhnd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [vhnd_pkg::BITS_W-1:0]        s_column_bits,
    input  logic                               s_frame_start,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [$clog2(MAX_COLUMNS)-1:0]     m_out_column,
    output logic [vhnd_pkg::ROW_W-1:0]         m_out_row,
    output logic signed [vhnd_pkg::DIFF_W-1:0] m_height_difference,
    output logic                               m_no_data,
    output logic                               m_frame_end
);

    import vhnd_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int CL_W   = $clog2(MAX_COLUMNS + 1);
    localparam int HW     = $clog2(MAX_DEPTH + 1);
    localparam int SUM_W  = HW + 3;
    localparam int MAG_W  = HW + 4;
    localparam int NUM_W  = HW + 5;
    localparam int SC_W   = MAG_W + FRACTION_BITS;
    localparam int K      = SC_W + 3;
    localparam int RC_W   = K + 1;
    localparam int PR_W   = SC_W + RC_W;

    localparam logic [63:0] ONE_K = 64'd1 << K;
    localparam logic [RC_W-1:0] RECIP1 = RC_W'(ONE_K);
    localparam logic [RC_W-1:0] RECIP2 = RC_W'((ONE_K + 64'd1) / 2);
    localparam logic [RC_W-1:0] RECIP3 = RC_W'((ONE_K + 64'd2) / 3);
    localparam logic [RC_W-1:0] RECIP4 = RC_W'((ONE_K + 64'd3) / 4);
    localparam logic [RC_W-1:0] RECIP5 = RC_W'((ONE_K + 64'd4) / 5);
    localparam logic [RC_W-1:0] RECIP6 = RC_W'((ONE_K + 64'd5) / 6);
    localparam logic [RC_W-1:0] RECIP7 = RC_W'((ONE_K + 64'd6) / 7);
    localparam logic [RC_W-1:0] RECIP8 = RC_W'((ONE_K + 64'd7) / 8);

    localparam logic [CL_W-1:0] COLS_MIN = CL_W'(3);
    localparam logic [CL_W-1:0] COLS_MAX = CL_W'(MAX_COLUMNS);
    localparam logic [ROW_CFG_W-1:0] ROWS_MIN  = ROW_CFG_W'(3);
    localparam logic [ROW_CFG_W-1:0] ROWS_LIM  = ROW_CFG_W'(ROWS_MAX);

    function automatic logic [RC_W-1:0] recip_of(input logic [COUNT_W-1:0] d);
        logic [RC_W-1:0] r;
        case (d)
            4'd1:    r = RECIP1;
            4'd2:    r = RECIP2;
            4'd3:    r = RECIP3;
            4'd4:    r = RECIP4;
            4'd5:    r = RECIP5;
            4'd6:    r = RECIP6;
            4'd7:    r = RECIP7;
            4'd8:    r = RECIP8;
            default: r = '0;
        endcase
        return r;
    endfunction

    // configuration
    logic [COL_CFG_W-1:0]   columns_reg;
    logic [ROW_CFG_W-1:0]   rows_reg;
    logic [DEPTH_CFG_W-1:0] depth_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
            depth_reg   <= DEPTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_COLUMNS: columns_reg <= cfg_data[COL_CFG_W-1:0];
                CFG_ROWS:    rows_reg    <= cfg_data[ROW_CFG_W-1:0];
                CFG_DEPTH:   depth_reg   <= cfg_data[DEPTH_CFG_W-1:0];
                default:     ;
            endcase
        end
    end

    // pipeline control
    logic m_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic en_out, en3, en2, fire1, accept;

    assign en_out = !m_valid_reg || m_ready;
    assign en3    = !s3_valid_reg || en_out;
    assign en2    = !s2_valid_reg || en3;
    assign fire1  = s1_valid_reg && en2;
    assign s_ready = !s1_valid_reg || en2;
    assign accept = s_valid && s_ready;

    // raster position
    logic [COL_W-1:0]     col_pos_reg, col_pos_next;
    logic [ROW_W-1:0]     row_pos_reg, row_pos_next;
    logic [CL_W-1:0]      cols_eff;
    logic [ROW_CFG_W-1:0] rows_eff;
    logic [COL_W-1:0]     cp;
    logic [ROW_W:0]       rp;
    logic [CL_W-1:0]      c_inc;
    logic [ROW_W:0]       r_inc;
    logic [COL_W-1:0]     cur_col;
    logic [ROW_W-1:0]     cur_row;
    logic                 cur_produce, cur_frame_end;
    logic [HW-1:0]        cur_height;

    always_comb begin
        cols_eff = (CL_W'(columns_reg) < COLS_MIN) ? COLS_MIN : CL_W'(columns_reg);
        if (32'(columns_reg) > 32'(MAX_COLUMNS)) begin
            cols_eff = COLS_MAX;
        end
        rows_eff = (rows_reg < ROWS_MIN) ? ROWS_MIN :
                   (rows_reg > ROWS_LIM) ? ROWS_LIM : rows_reg;

        cp = s_frame_start ? '0 : col_pos_reg;
        rp = s_frame_start ? '0 : {1'b0, row_pos_reg};
        if (CL_W'(cp) >= cols_eff) begin
            cp = '0;
            rp = rp + 1'b1;
        end
        if (rp >= rows_eff) begin
            rp = '0;
        end
        cur_col = cp;
        cur_row = rp[ROW_W-1:0];

        c_inc = CL_W'(cur_col) + 1'b1;
        r_inc = {1'b0, cur_row} + 1'b1;
        if (c_inc >= cols_eff) begin
            col_pos_next = '0;
            row_pos_next = (r_inc >= rows_eff) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            col_pos_next = c_inc[COL_W-1:0];
            row_pos_next = cur_row;
        end

        cur_produce   = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
        cur_frame_end = (CL_W'(cur_col) == cols_eff - 1'b1) &&
                        ({1'b0, cur_row} == rows_eff - 1'b1);
    end

    vhnd_height #(
        .MAX_DEPTH (MAX_DEPTH),
        .HEIGHT_W  (HW)
    ) u_height (
        .column_bits (s_column_bits),
        .depth       (depth_reg),
        .height      (cur_height)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end else if (accept) begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

    // stage 1: line store read-modify-write, window shift
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [HW-1:0]     s1_height_reg;
    logic              s1_produce_reg, s1_frame_end_reg;
    logic              s1_fwd_reg;
    logic [2*HW-1:0]   s1_fwd_data_reg;
    logic [2*HW-1:0]   ram_rdata, entry, wdata;
    logic [HW-1:0]     old_h, mid_h;
    logic [HW-1:0]     win_reg [9];
    logic [HW-1:0]     win_next [9];

    vhnd_ram #(
        .WIDTH (2 * HW),
        .DEPTH (MAX_COLUMNS)
    ) u_lines (
        .aclk  (aclk),
        .we    (fire1),
        .waddr (s1_col_reg),
        .wdata (wdata),
        .re    (accept),
        .raddr (cur_col),
        .rdata (ram_rdata)
    );

    always_comb begin
        entry = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
        if (s1_row_reg[0]) begin
            old_h = entry[2*HW-1:HW];
            mid_h = entry[HW-1:0];
            wdata = {s1_height_reg, entry[HW-1:0]};
        end else begin
            old_h = entry[HW-1:0];
            mid_h = entry[2*HW-1:HW];
            wdata = {entry[2*HW-1:HW], s1_height_reg};
        end
        for (int i = 0; i < 3; i++) begin
            win_next[i*3]     = win_reg[i*3 + 1];
            win_next[i*3 + 1] = win_reg[i*3 + 2];
        end
        win_next[2] = old_h;
        win_next[5] = mid_h;
        win_next[8] = s1_height_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (fire1) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg       <= cur_col;
            s1_row_reg       <= cur_row;
            s1_height_reg    <= cur_height;
            s1_produce_reg   <= cur_produce;
            s1_frame_end_reg <= cur_frame_end;
            s1_fwd_reg       <= s1_valid_reg && (s1_col_reg == cur_col);
            s1_fwd_data_reg  <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (fire1) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // neighbour sum and count over the shifted window
    logic [SUM_W-1:0]   nb_sum;
    logic [COUNT_W-1:0] nb_count;
    logic [MAG_W-1:0]   centre_scaled;
    logic               nodata_now;

    always_comb begin
        nb_sum   = '0;
        nb_count = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                nb_sum   = nb_sum + SUM_W'(win_next[i]);
                nb_count = nb_count + COUNT_W'(win_next[i] != '0);
            end
        end
        centre_scaled = MAG_W'(win_next[4]) * MAG_W'(nb_count);
        nodata_now    = (win_next[4] == '0) || (nb_count == '0);
    end

    // stage 2
    logic signed [NUM_W-1:0] s2_num_reg;
    logic [COUNT_W-1:0]      s2_count_reg;
    logic                    s2_nodata_reg, s2_frame_end_reg;
    logic [COL_W-1:0]        s2_col_reg;
    logic [ROW_W-1:0]        s2_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en2) begin
            s2_valid_reg <= fire1 && s1_produce_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_num_reg       <= $signed({1'b0, centre_scaled}) - $signed({2'b00, nb_sum});
            s2_count_reg     <= nb_count;
            s2_nodata_reg    <= nodata_now;
            s2_frame_end_reg <= s1_frame_end_reg;
            s2_col_reg       <= s1_col_reg - 1'b1;
            s2_row_reg       <= s1_row_reg - 1'b1;
        end
    end

    // stage 3: magnitude times reciprocal of the count
    logic [NUM_W-1:0] num_abs;
    logic [SC_W-1:0]  scaled;
    logic [PR_W-1:0]  s3_prod_reg;
    logic             s3_neg_reg, s3_nodata_reg, s3_frame_end_reg;
    logic [COL_W-1:0] s3_col_reg;
    logic [ROW_W-1:0] s3_row_reg;

    assign num_abs = s2_num_reg[NUM_W-1] ? (~s2_num_reg + 1'b1) : s2_num_reg;
    assign scaled  = SC_W'(num_abs[MAG_W-1:0]) << FRACTION_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en3) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            s3_prod_reg      <= PR_W'(scaled) * PR_W'(recip_of(s2_count_reg));
            s3_neg_reg       <= s2_num_reg[NUM_W-1];
            s3_nodata_reg    <= s2_nodata_reg;
            s3_frame_end_reg <= s2_frame_end_reg;
            s3_col_reg       <= s2_col_reg;
            s3_row_reg       <= s2_row_reg;
        end
    end

    // output: no-data zero, sign, saturation
    logic [SC_W-1:0]   quot;
    logic [31:0]       quot_x;
    logic [DIFF_W-1:0] diff_next;

    assign quot   = s3_prod_reg[K +: SC_W];
    assign quot_x = 32'(quot);

    always_comb begin
        if (s3_nodata_reg) begin
            diff_next = '0;
        end else if (!s3_neg_reg) begin
            diff_next = (quot_x > 32'(DIFF_MAX)) ? DIFF_W'(DIFF_MAX) : quot_x[DIFF_W-1:0];
        end else begin
            diff_next = (quot_x > 32'(DIFF_MIN_MAG)) ? DIFF_W'(DIFF_MIN_MAG) :
                        DIFF_W'(~quot_x + 32'd1);
        end
    end

    logic [COL_W-1:0]  m_col_reg;
    logic [ROW_W-1:0]  m_row_reg;
    logic [DIFF_W-1:0] m_diff_reg;
    logic              m_nodata_reg, m_frame_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en_out) begin
            m_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            m_col_reg       <= s3_col_reg;
            m_row_reg       <= s3_row_reg;
            m_diff_reg      <= diff_next;
            m_nodata_reg    <= s3_nodata_reg;
            m_frame_end_reg <= s3_frame_end_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_out_column        = m_col_reg;
    assign m_out_row           = m_row_reg;
    assign m_height_difference = $signed(m_diff_reg);
    assign m_no_data           = m_nodata_reg;
    assign m_frame_end         = m_frame_end_reg;

    `VHND_CHECK_NOW(a_accept_drains_s1, accept && s1_valid_reg, fire1,
        "word taken while stage 1 holds an unwritten entry")
    `VHND_CHECK_NEXT(a_frame_start_pos, accept && s_frame_start, col_pos_reg == COL_W'(1),
        "frame start did not restart the column position")
    `VHND_CHECK_NOW(a_nodata_zero, m_valid_reg && m_nodata_reg, m_diff_reg == '0,
        "no-data word carries a non-zero difference")
    `VHND_CHECK_NEXT(a_fwd_after_write, accept && s1_valid_reg && (s1_col_reg == cur_col),
        s1_fwd_reg, "same-entry forward not armed")

endmodule
